>>> rtl/kwbe_pkg.sv
`default_nettype none
package kwbe_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int CHAN_W    = 3;
  localparam int COEF_W    = 32;
  localparam int SIG_W     = 48;
  localparam int STEPLEN_W = 16;
  localparam int ENERGY_W  = 63;
  localparam int ACC_W     = 64;
  localparam int BLKNUM_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_COEF  = 7;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int MAG_W     = 31;
  localparam int WEIGHT_W  = 17;

  typedef logic signed [SIG_W-1:0]  sig_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ACC_W-1:0]         acc_t;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHELF_B0    = 3'd0,
    REG_SHELF_B1    = 3'd1,
    REG_SHELF_B2    = 3'd2,
    REG_SHELF_A1    = 3'd3,
    REG_SHELF_A2    = 3'd4,
    REG_HIGHPASS_A1 = 3'd5,
    REG_HIGHPASS_A2 = 3'd6,
    REG_STEP_LENGTH = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_ACC,
    ST_FRAME,
    ST_SUM,
    ST_OUT
  } state_t;

  // Weight 1.41 as 92406 / 65536.
  localparam logic [WEIGHT_W-1:0] WEIGHT_SURROUND = 17'd92406;
  localparam logic [CHAN_W-1:0]   CHAN_SURR_L     = 3'd3;
  localparam logic [CHAN_W-1:0]   CHAN_SURR_R     = 3'd4;

  localparam sig_t SIG_MAX = {1'b0, {(SIG_W-1){1'b1}}};
  localparam sig_t SIG_MIN = {1'b1, {(SIG_W-1){1'b0}}};
  localparam acc_t E_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [STEPLEN_W-1:0] STEP_LEN_RESET = 16'd4800;

  function automatic sig_t sat48(input prod_t v);
    if (v > prod_t'(SIG_MAX)) begin
      return SIG_MAX;
    end else if (v < prod_t'(SIG_MIN)) begin
      return SIG_MIN;
    end
    return v[SIG_W-1:0];
  endfunction

  function automatic acc_t add_sat(input acc_t a, input acc_t b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, E_MAX}) begin
      return E_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic coef_t coef_reset(input logic [CFG_IDX_W-1:0] idx);
    case (idx)
      REG_SHELF_B0:    return 32'sd824163884;
      REG_SHELF_B1:    return -32'sd1445093387;
      REG_SHELF_B2:    return 32'sd643382241;
      REG_SHELF_A1:    return -32'sd907665796;
      REG_SHELF_A2:    return 32'sd393247619;
      REG_HIGHPASS_A1: return -32'sd1068398589;
      REG_HIGHPASS_A2: return 32'sd531540992;
      default:         return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> rtl/kwbe_if.sv
`default_nettype none
interface kwbe_in_if import kwbe_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [CHAN_W-1:0]          channel;
  logic                       frame_end;
  modport source (output valid, sample, channel, frame_end, input ready);
  modport sink   (input valid, sample, channel, frame_end, output ready);
endinterface

interface kwbe_out_if import kwbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] block_energy;
  logic [BLKNUM_W-1:0] block_number;
  modport source (output valid, block_energy, block_number, input ready);
  modport sink   (input valid, block_energy, block_number, output ready);
endinterface

interface kwbe_cfg_if import kwbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/kwbe_mul.sv
`default_nettype none
module kwbe_mul import kwbe_pkg::*; (
  input  wire logic    clk,
  input  wire logic    en,
  input  wire mul_op_t op_a,
  input  wire mul_op_t op_b,
  output prod_t        prod_r
);

  prod_t prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/k_weighted_block_energy_unit.sv
// Channel  Dir  Word contents
// in_ch    in   sample (Q1.23), channel, frame_end
// out_ch   out  block_energy (63 bit, saturated), block_number
// cfg_ch   in   index, data (coefficients Q3.29, step length)
//
// A sample word is taken in the idle state and then goes through one shared 33x33
// multiplier (seven coefficient products of two partial products each, the square
// and two weight products), the accumulate state and the frame accounting state.
// A step close that completes a block goes on to summing the block's steps and then
// loads the output register. in_ch.ready is high only when idle.
// Reset (rst_n low, synchronous) clears all filter state and counters.
// A block result waits in the output register; the block stalls only when a new
// block is ready before the previous word has been taken.
`default_nettype none
module k_weighted_block_energy_unit import kwbe_pkg::*; #(
  parameter int MAX_CHANNELS    = 8,
  parameter int STEPS_PER_BLOCK = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  kwbe_in_if.sink     in_ch,
  kwbe_out_if.source  out_ch,
  kwbe_cfg_if.sink    cfg_ch
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int KW   = $clog2(STEPS_PER_BLOCK + 1);
  localparam int PW   = (STEPS_PER_BLOCK > 1) ? $clog2(STEPS_PER_BLOCK) : 1;
  localparam logic [4:0] CNT_SQUARE = 5'd14;
  localparam logic [4:0] CNT_WHI    = 5'd15;
  localparam logic [4:0] CNT_WLO    = 5'd16;
  localparam logic [4:0] CNT_LAST   = 5'd17;
  localparam prod_t ROUND_Q = prod_t'(1) <<< 28;

  state_t state_r, state_nxt;
  logic [4:0] cnt_r;

  coef_t                coef_r [NUM_COEF];
  logic [STEPLEN_W-1:0] step_len_r;

  sig_t sd1_r [MAX_CHANNELS];
  sig_t sd2_r [MAX_CHANNELS];
  sig_t hd1_r [MAX_CHANNELS];
  sig_t hd2_r [MAX_CHANNELS];

  sig_t              x_r, y1_r, y2_r;
  sig_t              mq_r [NUM_COEF];
  logic [CHAN_W-1:0] ch_r;
  logic [CH_W-1:0]   cidx_r;
  logic              fend_r;
  logic [MAG_W-1:0]  m_r;
  logic [61:0]       sq_r;
  prod_t             plo_r, whi_r;
  acc_t              wsq_r;

  acc_t                 step_r, sum_r;
  acc_t                 prev_r [STEPS_PER_BLOCK];
  logic [STEPLEN_W-1:0] fc_r;
  logic [KW-1:0]        seen_r, k_r;
  logic [BLKNUM_W-1:0]  blk_r;

  logic                out_valid_r;
  logic [ENERGY_W-1:0] out_energy_r;
  logic [BLKNUM_W-1:0] out_number_r;

  logic    in_acc, ch_ok, do_out, filt_en;
  mul_op_t op_a, op_b;
  prod_t   prod_r, comb_prod;
  sig_t    comb_sig, sig_sel, mq_new;
  logic [2:0] q;
  logic [SIG_W-1:0]    y_abs;
  logic [SIG_W:0]      y_rnd;
  logic [SIG_W-12:0]   m_full;
  logic [79:0]         wsum;
  logic [STEPLEN_W-1:0] fc_inc, len;
  logic                step_open, blk_full;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign ch_ok   = int'(in_ch.channel) < MAX_CHANNELS;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.block_energy = out_energy_r;
  assign out_ch.block_number = out_number_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ch_ok ? ST_FILT : ST_FRAME;
      ST_FILT:  if (cnt_r == CNT_LAST) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_FRAME;
      ST_FRAME: begin
        if (!fend_r || step_open) begin
          state_nxt = ST_IDLE;
        end else if (blk_full) begin
          state_nxt = ST_SUM;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM:   if (k_r == KW'(STEPS_PER_BLOCK - 1)) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    filt_en     = 1'b0;
    do_out      = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_FILT:  filt_en = 1'b1;
      ST_OUT:   do_out = !out_valid_r || out_ch.ready;
      default:  ;
    endcase
  end

  always_comb begin
    fc_inc    = fc_r + 1'b1;
    len       = (step_len_r == '0) ? STEP_LEN_RESET / STEP_LEN_RESET : step_len_r;
    step_open = (fc_inc < len) && (fc_inc != '0);
    blk_full  = seen_r >= KW'(STEPS_PER_BLOCK - 1);
  end

  // Shared multiplier operand selection.
  always_comb begin
    q = cnt_r[3:1];
    if (q < 3'd3) begin
      sig_sel = x_r;
    end else if (q < 3'd5) begin
      sig_sel = y1_r;
    end else begin
      sig_sel = y2_r;
    end
    op_a = '0;
    op_b = '0;
    if (cnt_r < CNT_SQUARE) begin
      op_a = mul_op_t'(coef_r[q]);
      op_b = cnt_r[0] ? mul_op_t'($signed(sig_sel[SIG_W-1:24]))
                      : mul_op_t'({9'b0, sig_sel[23:0]});
    end else if (cnt_r == CNT_SQUARE) begin
      op_a = {2'b0, m_r};
      op_b = {2'b0, m_r};
    end else if (cnt_r == CNT_WHI) begin
      op_a = {2'b0, prod_r[61:31]};
      op_b = mul_op_t'({1'b0, WEIGHT_SURROUND});
    end else if (cnt_r == CNT_WLO) begin
      op_a = {2'b0, sq_r[30:0]};
      op_b = mul_op_t'({1'b0, WEIGHT_SURROUND});
    end
  end

  kwbe_mul u_mul (
    .clk    (clk),
    .en     (filt_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Rounded coefficient product from the two partial products.
  always_comb begin
    comb_prod = prod_r + ((plo_r + ROUND_Q) >>> 24);
    mq_new    = sat48(comb_prod >>> 5);
    comb_sig  = sat48(prod_t'(mq_r[0]) + prod_t'(sd1_r[cidx_r]));
    y_abs     = y2_r[SIG_W-1] ? SIG_W'(-y2_r) : SIG_W'(y2_r);
    y_rnd     = {1'b0, y_abs} + (SIG_W+1)'(2048);
    m_full    = y_rnd[SIG_W:12];
    wsum      = {whi_r[48:0], 31'b0} + 80'(prod_r[48:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FILT) begin
        cnt_r <= cnt_r + 1'b1;
      end else begin
        cnt_r <= '0;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= coef_reset(CFG_IDX_W'(i));
      end
      step_len_r <= STEP_LEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_STEP_LENGTH) begin
        step_len_r <= cfg_ch.data[STEPLEN_W-1:0];
      end else begin
        coef_r[cfg_ch.index] <= cfg_ch.data;
      end
    end
  end

  // Filter datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= {{15{in_ch.sample[SAMPLE_W-1]}}, in_ch.sample, 9'b0};
      ch_r   <= in_ch.channel;
      cidx_r <= CH_W'(in_ch.channel);
      fend_r <= in_ch.frame_end;
    end
    if (filt_en) begin
      plo_r <= prod_r;
      if (cnt_r >= 5'd2 && cnt_r <= CNT_SQUARE && !cnt_r[0]) begin
        mq_r[cnt_r[3:1] - 3'd1] <= mq_new;
      end
      if (cnt_r == 5'd3) begin
        y1_r <= comb_sig;
      end
      if (cnt_r == 5'd4) begin
        y2_r <= sat48(prod_t'(y1_r) + prod_t'(hd1_r[cidx_r]));
      end
      if (cnt_r == 5'd5) begin
        m_r <= (m_full > (SIG_W-11)'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : m_full[MAG_W-1:0];
      end
      if (cnt_r == CNT_WHI) begin
        sq_r <= prod_r[61:0];
      end
      if (cnt_r == CNT_WLO) begin
        whi_r <= prod_r;
      end
      if (cnt_r == CNT_LAST) begin
        if (ch_r == CHAN_SURR_L || ch_r == CHAN_SURR_R) begin
          wsq_r <= wsum[79:16];
        end else begin
          wsq_r <= {2'b0, sq_r};
        end
      end
    end
  end

  // Per-channel filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sd1_r[i] <= '0;
        sd2_r[i] <= '0;
        hd1_r[i] <= '0;
        hd2_r[i] <= '0;
      end
    end else if (filt_en && cnt_r == CNT_WHI) begin
      sd1_r[cidx_r] <= sat48(prod_t'(mq_r[1]) - prod_t'(mq_r[3]) + prod_t'(sd2_r[cidx_r]));
      sd2_r[cidx_r] <= sat48(prod_t'(mq_r[2]) - prod_t'(mq_r[4]));
      hd1_r[cidx_r] <= sat48(-(prod_t'(y1_r) <<< 1) - prod_t'(mq_r[5])
                             + prod_t'(hd2_r[cidx_r]));
      hd2_r[cidx_r] <= sat48(prod_t'(y1_r) - prod_t'(mq_r[6]));
    end
  end

  // Step and block accounting.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      fc_r        <= '0;
      seen_r      <= '0;
      k_r         <= '0;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STEPS_PER_BLOCK; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready && !do_out) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_ACC: step_r <= add_sat(step_r, wsq_r);
        ST_FRAME: begin
          if (fend_r) begin
            if (step_open) begin
              fc_r <= fc_inc;
            end else if (blk_full) begin
              sum_r <= step_r;
              k_r   <= '0;
            end else begin
              seen_r <= seen_r + 1'b1;
              for (int i = STEPS_PER_BLOCK - 1; i > 0; i--) begin
                prev_r[i] <= prev_r[i-1];
              end
              prev_r[0] <= step_r;
              step_r    <= '0;
              fc_r      <= '0;
            end
          end
        end
        ST_SUM: begin
          if (k_r != KW'(STEPS_PER_BLOCK - 1)) begin
            sum_r <= add_sat(sum_r, prev_r[k_r[PW-1:0]]);
            k_r   <= k_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (do_out) begin
            out_valid_r  <= 1'b1;
            out_energy_r <= sum_r[ENERGY_W-1:0];
            out_number_r <= blk_r;
            blk_r        <= blk_r + 1'b1;
            for (int i = STEPS_PER_BLOCK - 1; i > 0; i--) begin
              prev_r[i] <= prev_r[i-1];
            end
            prev_r[0] <= step_r;
            step_r    <= '0;
            fc_r      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/kwbe_checker.sv
`default_nettype none
module kwbe_checker import kwbe_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [ENERGY_W-1:0] out_energy,
  input wire logic                cfg_ready
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy))
    else $error("result word changed while stalled");

  // In the cycle after a sample is taken, the block is busy and in_ready is low.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in back-to-back cycles");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind k_weighted_block_energy_unit kwbe_checker u_kwbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_energy (out_ch.block_energy),
  .cfg_ready  (cfg_ch.ready)
);
`default_nettype wire

>>> dv/k_weighted_block_energy_checker.sv
`default_nettype none
module k_weighted_block_energy_checker import kwbe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  kwbe_in_if        in_mon,
  kwbe_out_if       out_mon,
  kwbe_cfg_if       cfg_mon,
  output int        fail_count,
  output int        blocks_waiting,
  output int        words_in,
  output int        blocks_seen,
  output int        writes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [BLKNUM_W-1:0] number;
  } block_word_t;

  block_word_t expected_blocks[$];

  coef_t                coefs[NUM_COEF];
  logic [STEPLEN_W-1:0] frames_per_step;
  longint               shelf_z1[8], shelf_z2[8], hp_z1[8], hp_z2[8];
  acc_t                 step_sum;
  acc_t                 older_steps[3];
  logic [15:0]          frames_in_step;
  int                   closed_steps;
  logic [BLKNUM_W-1:0]  next_block;

  localparam longint SIG_HI = 64'sd140737488355327;
  localparam longint SIG_LO = -SIG_HI - 1;

  function automatic longint clip48(input longint v);
    if (v > SIG_HI) begin
      return SIG_HI;
    end else if (v < SIG_LO) begin
      return SIG_LO;
    end
    return v;
  endfunction

  // Q3.29 times Q.32, split so every partial fits, rounded half up to Q.32.
  function automatic longint coef_mul(input coef_t c, input longint s);
    longint cl, lo, hi, m;
    cl = longint'(c);
    lo = s & 64'hFF_FFFF;
    hi = s >>> 24;
    m  = cl * hi + ((cl * lo + (64'sd1 <<< 28)) >>> 24);
    return clip48(m >>> 5);
  endfunction

  function automatic acc_t energy_add(input acc_t a, input acc_t b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, E_MAX}) begin
      return E_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

  task automatic predict_word(input logic signed [SAMPLE_W-1:0] smp,
                              input logic [CHAN_W-1:0] ch, input logic fend);
    longint x, y1, y2, mag;
    logic [63:0] m, sq, wsq;
    logic [15:0] len;
    acc_t total;
    block_word_t bw;
    x   = longint'(smp) * 512;
    len = (frames_per_step == 0) ? 16'd1 : frames_per_step;

    y1 = clip48(coef_mul(coefs[REG_SHELF_B0], x) + shelf_z1[ch]);
    shelf_z1[ch] = clip48(coef_mul(coefs[REG_SHELF_B1], x)
                          - coef_mul(coefs[REG_SHELF_A1], y1) + shelf_z2[ch]);
    shelf_z2[ch] = clip48(coef_mul(coefs[REG_SHELF_B2], x)
                          - coef_mul(coefs[REG_SHELF_A2], y1));
    y2 = clip48(y1 + hp_z1[ch]);
    hp_z1[ch] = clip48(-2 * y1 - coef_mul(coefs[REG_HIGHPASS_A1], y2) + hp_z2[ch]);
    hp_z2[ch] = clip48(y1 - coef_mul(coefs[REG_HIGHPASS_A2], y2));

    mag = (y2 < 0) ? -y2 : y2;
    m   = (mag + 2048) >> 12;
    if (m > 64'h7FFF_FFFF) begin
      m = 64'h7FFF_FFFF;
    end
    sq = m * m;
    if (ch == CHAN_SURR_L || ch == CHAN_SURR_R) begin
      wsq = (sq >> 16) * 92406 + (((sq & 64'hFFFF) * 92406) >> 16);
    end else begin
      wsq = sq;
    end
    step_sum = energy_add(step_sum, wsq);

    if (fend) begin
      frames_in_step = frames_in_step + 16'd1;
      if (!(frames_in_step < len && frames_in_step != 0)) begin
        if (closed_steps >= 3) begin
          total = step_sum;
          for (int k = 0; k < 3; k++) total = energy_add(total, older_steps[k]);
          bw.energy = total[ENERGY_W-1:0];
          bw.number = next_block;
          expected_blocks = {expected_blocks, bw};
          next_block = next_block + 1;
        end else begin
          closed_steps++;
        end
        older_steps[2] = older_steps[1];
        older_steps[1] = older_steps[0];
        older_steps[0] = step_sum;
        step_sum = '0;
        frames_in_step = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    block_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) coefs[i] = coef_reset(CFG_IDX_W'(i));
      frames_per_step = STEP_LEN_RESET;
      for (int i = 0; i < 8; i++) begin
        shelf_z1[i] = 0; shelf_z2[i] = 0; hp_z1[i] = 0; hp_z2[i] = 0;
      end
      step_sum = '0;
      for (int i = 0; i < 3; i++) older_steps[i] = '0;
      frames_in_step = '0;
      closed_steps = 0;
      next_block = '0;
      expected_blocks.delete();
      fail_count = 0;
      words_in = 0;
      blocks_seen = 0;
      writes_seen = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        writes_seen++;
        if (cfg_mon.index == REG_STEP_LENGTH) begin
          frames_per_step = cfg_mon.data[STEPLEN_W-1:0];
        end else begin
          coefs[cfg_mon.index] = cfg_mon.data;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        words_in++;
        predict_word(in_mon.sample, in_mon.channel, in_mon.frame_end);
      end
      if (out_mon.valid && out_mon.ready) begin
        blocks_seen++;
        if (expected_blocks.size() == 0) begin
          $error("block word %0d arrived with none expected", out_mon.block_number);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_mon.block_energy !== want.energy) begin
            $error("block_energy: expected %0d, actual %0d", want.energy,
                   out_mon.block_energy);
            fail_count++;
          end
          if (out_mon.block_number !== want.number) begin
            $error("block_number: expected %0d, actual %0d", want.number,
                   out_mon.block_number);
            fail_count++;
          end
        end
      end
    end
    blocks_waiting = expected_blocks.size();
  end

endmodule
`default_nettype wire

>>> dv/k_weighted_block_energy_unit_tb.sv
`default_nettype none
module k_weighted_block_energy_unit_tb;
  import kwbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kwbe_in_if  in_ch();
  kwbe_out_if out_ch();
  kwbe_cfg_if cfg_ch();

  int fail_count, blocks_waiting, words_in, blocks_seen, writes_seen;
  int words_sent = 0;
  int quiet_cycles;
  bit no_idling = 1'b0;
  bit hold_request = 1'b0;

  k_weighted_block_energy_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  k_weighted_block_energy_checker energy_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .blocks_waiting(blocks_waiting), .words_in(words_in),
    .blocks_seen(blocks_seen), .writes_seen(writes_seen)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: short random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    int stall_left, hold_left;
    bit hold_taken;
    if (hold_request && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = 400;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!no_idling && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] smp, input logic [CHAN_W-1:0] ch,
                           input logic fend);
    int gap;
    @(negedge clk);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.channel <= ch;
    in_ch.frame_end <= fend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [COEF_W-1:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Words that close no step may still be in flight after the last block word.
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (blocks_waiting != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_coefs(input int mode);
    logic [COEF_W-1:0] c;
    for (int i = 0; i < NUM_COEF; i++) begin
      case (mode)
        0: c = coef_reset(CFG_IDX_W'(i));
        1: c = 32'h7FFF_FFFF;
        2: c = 32'h8000_0000;
        3: c = coef_reset(CFG_IDX_W'(i)) + $urandom_range(0, 131072) - 65536;
        default: c = $urandom;
      endcase
      write_reg(reg_idx_t'(i), c);
    end
  endtask

  // Mostly proper frames of 1 to 8 channels; a share of stray words.
  task automatic send_frames(input int frames, input int noise_pct);
    int nch;
    logic [SAMPLE_W-1:0] smp;
    for (int f = 0; f < frames; f++) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_word(SAMPLE_W'($urandom), CHAN_W'($urandom), 1'($urandom));
      end else begin
        nch = $urandom_range(1, 8);
        for (int c = 0; c < nch; c++) begin
          smp = SAMPLE_W'($urandom);
          if ($urandom_range(0, 2) == 0) smp = $signed(smp) >>> $urandom_range(4, 20);
          send_word(smp, CHAN_W'(c), c == nch - 1);
        end
      end
      if (words_sent > 1450) no_idling = 1'b1;
    end
  endtask

  initial begin
    int mode;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.channel = '0;
    in_ch.frame_end = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SHELF_B0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset coefficients, one frame per step, field extremes.
    load_coefs(0);
    write_reg(REG_STEP_LENGTH, 32'd1);
    send_word(24'h7FFFFF, 3'd0, 1'b0);
    send_word(24'h800000, 3'd1, 1'b0);
    send_word(24'h000000, 3'd2, 1'b0);
    send_word(24'h000001, 3'd3, 1'b0);
    send_word(24'hFFFFFF, 3'd4, 1'b0);
    send_word(24'h7FFFFF, 3'd5, 1'b0);
    send_word(24'h800000, 3'd6, 1'b0);
    send_word(24'h555555, 3'd7, 1'b1);
    for (int i = 0; i < 8; i++) send_word(i[0] ? 24'h800000 : 24'h7FFFFF, CHAN_W'(i), 1'b1);
    for (int i = 0; i < 8; i++) send_word(24'hAAAAAA, CHAN_W'(3 + (i % 2)), i[0]);
    wait_quiet();

    // Largest and smallest coefficients drive the filters and sums into saturation;
    // a step length of zero behaves as one.
    load_coefs(1);
    write_reg(REG_STEP_LENGTH, 32'd0);
    send_frames(12, 0);
    wait_quiet();
    load_coefs(2);
    write_reg(REG_STEP_LENGTH, 32'd3);
    send_frames(16, 10);
    wait_quiet();

    // Longest step, then shortened while a step is open: it closes at the next frame end.
    load_coefs(0);
    write_reg(REG_STEP_LENGTH, 32'hFFFF);
    send_frames(10, 0);
    wait_quiet();
    write_reg(REG_STEP_LENGTH, 32'd2);
    send_frames(12, 0);
    wait_quiet();

    // Long hold-off on the result side while words keep coming.
    write_reg(REG_STEP_LENGTH, 32'd1);
    hold_request = 1'b1;
    send_frames(30, 0);
    wait_quiet();

    while (words_sent < 1650) begin
      mode = $urandom_range(0, 9);
      load_coefs(mode < 5 ? 0 : (mode < 8 ? 3 : 4));
      write_reg(REG_STEP_LENGTH, $urandom_range(1, 4));
      send_frames($urandom_range(15, 40), 10);
      wait_quiet();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d sample words and %0d register writes; %0d block words checked.",
             words_in, writes_seen, blocks_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
